FILE: rtl/core/lzrgd_pkg.sv
// ----------------------------------------------------------------------------
// lzrgd_pkg
// Shared types and constants of the LZ/RLE graphics decompressor.
// ----------------------------------------------------------------------------
package lzrgd_pkg;

  localparam int HISTORY_DEPTH_DEF = 1024;
  localparam int QUEUE_DEPTH_DEF   = 2;

  // Fixed by the compressed format: the offset field is ten bits wide.
  localparam int OFS_W = 10;
  localparam int CNT_W = 6;

  localparam logic [7:0]       CTRL_LIT   = 8'h80;
  localparam logic [7:0]       CTRL_PAD   = 8'hA0;
  localparam logic [7:0]       CTRL_REP   = 8'hC0;
  localparam logic [7:0]       CTRL_ZERO  = 8'hE0;
  localparam logic [7:0]       LIT_OPEN   = 8'h80;
  localparam logic [OFS_W-1:0] OFS_BIAS   = 10'h3DF;
  localparam logic [CNT_W-1:0] RUN_EXTRA  = 6'd2;

  typedef enum logic [2:0] {
    PH_CONTROL,
    PH_OFFSET,
    PH_LITERAL,
    PH_PAD,
    PH_REPEAT
  } lzrgd_phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_COPY,
    BK_EMIT
  } lzrgd_bstate_t;

  // One unit of work handed from the decoder to the output engine.
  typedef struct packed {
    logic [7:0]       val;
    logic [CNT_W-1:0] cnt;
    logic             lead;
    logic             copy;
    logic [OFS_W-1:0] ofs;
    logic             clr;
  } lzrgd_job_t;

  // Status of the output engine, for checking.
  typedef struct packed {
    logic idle;
    logic bypass;
    logic dist_one;
    logic cnt_zero;
    logic busy;
  } lzrgd_bstat_t;

endpackage

FILE: rtl/core/lzrgd_ram.sv
// ----------------------------------------------------------------------------
// lzrgd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lzrgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

FILE: rtl/core/lzrgd_front.sv
// ----------------------------------------------------------------------------
// lzrgd_front
// Command decoder: takes compressed beats and turns them into output jobs.
// ----------------------------------------------------------------------------
module lzrgd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  input  logic                  q_full,
  output logic                  q_push,
  output lzrgd_pkg::lzrgd_job_t q_job
);
  import lzrgd_pkg::*;

  lzrgd_phase_t     phase_r, phase_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [7:0]       held_r, held_nxt;
  logic             accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CONTROL;
      rem_r   <= '0;
      held_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      held_r  <= held_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    held_nxt  = held_r;
    q_job     = '0;
    q_push    = 1'b0;
    if (accept) begin
      case (phase_r)
        PH_CONTROL: begin
          held_nxt = in_byte;
          if (in_byte < CTRL_LIT) begin
            phase_nxt = PH_OFFSET;
          end else if (in_byte < CTRL_PAD) begin
            rem_nxt   = CNT_W'(in_byte[4:0]);
            phase_nxt = PH_LITERAL;
          end else if (in_byte < CTRL_REP) begin
            rem_nxt   = CNT_W'(in_byte[4:0]) + RUN_EXTRA;
            phase_nxt = PH_PAD;
          end else if (in_byte[5] == 1'b0) begin
            phase_nxt = PH_REPEAT;
          end else begin
            q_job.cnt = CNT_W'(in_byte[4:0]) + RUN_EXTRA;
          end
        end
        PH_OFFSET: begin
          q_job.copy = 1'b1;
          q_job.cnt  = CNT_W'(held_r[6:2]) + RUN_EXTRA;
          q_job.ofs  = {held_r[1:0], in_byte} - OFS_BIAS;
          phase_nxt  = PH_CONTROL;
        end
        PH_LITERAL: begin
          q_job.val = in_byte;
          q_job.cnt = CNT_W'(1);
          if (held_r != LIT_OPEN) begin
            rem_nxt = rem_r - CNT_W'(1);
            if (rem_nxt == '0) begin
              phase_nxt = PH_CONTROL;
            end
          end
        end
        PH_PAD: begin
          q_job.val  = in_byte;
          q_job.cnt  = CNT_W'(2);
          q_job.lead = 1'b1;
          rem_nxt    = rem_r - CNT_W'(1);
          if (rem_nxt == '0) begin
            phase_nxt = PH_CONTROL;
          end
        end
        PH_REPEAT: begin
          q_job.val = in_byte;
          q_job.cnt = CNT_W'(held_r[4:0]) + RUN_EXTRA;
          phase_nxt = PH_CONTROL;
        end
        default: begin
          phase_nxt = PH_CONTROL;
        end
      endcase
      if (in_last) begin
        phase_nxt = PH_CONTROL;
        rem_nxt   = '0;
        held_nxt  = '0;
        q_job.clr = 1'b1;
      end
      q_push = (q_job.cnt != '0) || in_last;
    end
  end

endmodule

FILE: rtl/core/lzrgd_queue.sv
// ----------------------------------------------------------------------------
// lzrgd_queue
// Small register FIFO of jobs between the decoder and the output engine.
// ----------------------------------------------------------------------------
module lzrgd_queue #(
  parameter int DEPTH = lzrgd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  lzrgd_pkg::lzrgd_job_t push_job,
  output logic                  full,
  input  logic                  pop,
  output lzrgd_pkg::lzrgd_job_t head_job,
  output logic                  empty
);
  import lzrgd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lzrgd_job_t    mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: rtl/core/lzrgd_back.sv
// ----------------------------------------------------------------------------
// lzrgd_back
// Output engine: runs jobs byte by byte, keeps the history ring and the
// output register.
// ----------------------------------------------------------------------------
module lzrgd_back #(
  parameter int HISTORY_DEPTH = lzrgd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  lzrgd_pkg::lzrgd_job_t   q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_byte,
  output logic                    out_run_last,
  output lzrgd_pkg::lzrgd_bstat_t bstat
);
  import lzrgd_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int DW = AW + 1;

  lzrgd_bstate_t    state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       val_r, val_nxt;
  logic             lead_r, lead_nxt;
  logic             clr_r, clr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [DW-1:0]    dist_r, dist_nxt;
  logic [AW-1:0]    wp_r, wp_nxt;
  logic             past_r, past_nxt;
  logic             byp_r, byp_nxt;
  logic [7:0]       byp_data_r, byp_data_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;

  logic             adv;
  logic             emit;
  logic [7:0]       emit_byte;
  logic             emit_end;
  logic             ram_rd_en;
  logic [AW-1:0]    ram_rd_addr;
  logic [7:0]       ram_rd_data;
  logic [AW-1:0]    job_ofs;
  logic [AW-1:0]    wp_inc;
  logic             before_start;

  lzrgd_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (emit),
    .wr_addr (wp_r),
    .wr_data (emit_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign adv          = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_last_r;
  assign job_ofs      = AW'(q_head.ofs);
  assign wp_inc       = wp_r + AW'(1);
  assign before_start = !past_r && ({1'b0, wp_r} < dist_r);

  assign bstat.idle     = (state_r == BK_IDLE);
  assign bstat.bypass   = byp_r && (state_r == BK_COPY);
  assign bstat.dist_one = (dist_r == DW'(1));
  assign bstat.cnt_zero = (cnt_r == '0);
  assign bstat.busy     = (state_r == BK_COPY) || (state_r == BK_EMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      wp_r        <= '0;
      past_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      byp_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      past_r      <= past_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      byp_r       <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    lead_r     <= lead_nxt;
    clr_r      <= clr_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    dist_r     <= dist_nxt;
    byp_data_r <= byp_data_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    val_nxt       = val_r;
    lead_nxt      = lead_r;
    clr_nxt       = clr_r;
    rd_ptr_nxt    = rd_ptr_r;
    dist_nxt      = dist_r;
    wp_nxt        = wp_r;
    past_nxt      = past_r;
    byp_nxt       = byp_r;
    byp_data_nxt  = byp_data_r;
    q_pop         = 1'b0;
    emit          = 1'b0;
    emit_byte     = '0;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = rd_ptr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          cnt_nxt    = q_head.cnt;
          val_nxt    = q_head.val;
          lead_nxt   = q_head.lead;
          clr_nxt    = q_head.clr;
          rd_ptr_nxt = job_ofs;
          // Copy distance behind the write slot, one to the full ring.
          if (job_ofs < wp_r) begin
            dist_nxt = {1'b0, wp_r} - {1'b0, job_ofs};
          end else begin
            dist_nxt = {1'b0, wp_r} + DW'(HISTORY_DEPTH) - {1'b0, job_ofs};
          end
          if (q_head.cnt == '0) begin
            if (q_head.clr) begin
              wp_nxt   = '0;
              past_nxt = 1'b0;
            end
          end else if (q_head.copy) begin
            state_nxt = BK_READ;
          end else begin
            state_nxt = BK_EMIT;
          end
        end
      end
      BK_READ: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = rd_ptr_r;
        byp_nxt     = 1'b0;
        state_nxt   = BK_COPY;
      end
      BK_COPY: begin
        if (adv) begin
          emit = 1'b1;
          if (before_start) begin
            emit_byte = '0;
          end else if (byp_r) begin
            emit_byte = byp_data_r;
          end else begin
            emit_byte = ram_rd_data;
          end
          // Prefetch the next source byte; a byte written this cycle is
          // forwarded around the ring.
          ram_rd_en    = 1'b1;
          ram_rd_addr  = rd_ptr_r + AW'(1);
          rd_ptr_nxt   = rd_ptr_r + AW'(1);
          byp_nxt      = ((rd_ptr_r + AW'(1)) == wp_r);
          byp_data_nxt = emit_byte;
        end
      end
      BK_EMIT: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = lead_r ? 8'h00 : val_r;
          lead_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    emit_end = emit && (cnt_r == CNT_W'(1));
    if (emit) begin
      cnt_nxt       = cnt_r - CNT_W'(1);
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      out_last_nxt  = emit_end;
      wp_nxt        = wp_inc;
      if (wp_inc == '0) begin
        past_nxt = 1'b1;
      end
      if (emit_end) begin
        state_nxt = BK_IDLE;
        if (clr_r) begin
          wp_nxt   = '0;
          past_nxt = 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/core/lz_rle_graphics_decompressor_unit.sv
// A result byte reaches out_valid through the job queue, the output engine's
// idle state, its emit or copy state and the output register; a copy also
// passes the ring read state. Within a command the engine gives one result
// byte per cycle while the sink does not stall. Every job starts from the
// idle state, and a literal run is split into one job per byte.
// Reset: synchronous, active low; control state clears, the history ring does
// not and needs no clearing pass, since bytes before stream start read as zero.
// ----------------------------------------------------------------------------
// lz_rle_graphics_decompressor_unit
// LZ77 / RLE hybrid decompressor with a 1024-byte history window.
// ----------------------------------------------------------------------------
module lz_rle_graphics_decompressor_unit #(
  parameter int HISTORY_DEPTH = lzrgd_pkg::HISTORY_DEPTH_DEF,
  parameter int QUEUE_DEPTH   = lzrgd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last
);
  import lzrgd_pkg::*;

  // The decoder (front) reads control and argument beats and turns each one
  // into at most one job: a run of a fixed byte (optionally led by a zero,
  // for pad pairs) or a copy out of the history ring. Beats that only set up
  // a command produce no job unless they end the stream.
  lzrgd_job_t   push_job;
  lzrgd_job_t   head_job;
  logic         q_push;
  logic         q_full;
  logic         q_pop;
  logic         q_empty;
  lzrgd_bstat_t bstat;

  lzrgd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  // The job queue lets the decoder keep taking beats while the output
  // engine is busy with a long run; the input stalls only when it is full.
  lzrgd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty)
  );

  // The output engine writes every result byte into the ring and drives the
  // output register, which keeps a finished byte while the sink stalls. The
  // write position and the wrap flag live here, since copy distances and
  // the stream-start check depend on them.
  lzrgd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_head       (head_job),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .bstat        (bstat)
  );

  // The decoder never pushes into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("job pushed into a full queue");

  // The engine only pops when it is idle and a job is waiting.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (bstat.idle && !q_empty))
    else $error("job popped outside idle or from an empty queue");

  // Forwarding of a just-written byte is only needed at distance one.
  assert property (@(posedge clk) disable iff (!rst_n)
    bstat.bypass |-> bstat.dist_one)
    else $error("ring forwarding at a distance other than one");

  // An active run always has bytes left to produce.
  assert property (@(posedge clk) disable iff (!rst_n)
    bstat.busy |-> !bstat.cnt_zero)
    else $error("engine busy with an empty run");

  // Nothing is shown on the output right after reset.
  assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

FILE: tb/lzrgd_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzrgd_stream_checker
// Watches both channels of the decompressor, decodes every accepted input
// beat into the bytes it must produce and compares them with the output beats.
// ----------------------------------------------------------------------------
module lzrgd_stream_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_run_last,
  output int         fail_count,
  output int         pending_bytes
);
  import lzrgd_pkg::*;

  typedef struct {
    logic [7:0] value;
    logic       run_last;
  } decoded_t;

  decoded_t         expected_bytes[$];
  logic [7:0]       history[HISTORY_DEPTH_DEF];
  logic [OFS_W-1:0] wr_pos;
  logic             wrapped;
  lzrgd_phase_t     phase;
  logic [CNT_W-1:0] remain;
  logic [7:0]       held;
  int               fails;

  initial begin
    for (int i = 0; i < HISTORY_DEPTH_DEF; i++) history[i] = 8'h00;
    fails = 0;
    fail_count = 0;
    pending_bytes = 0;
  end

  function automatic void clear_decoder();
    wr_pos  = '0;
    wrapped = 1'b0;
    phase   = PH_CONTROL;
    remain  = '0;
    held    = 8'h00;
  endfunction

  function automatic void emit_byte(input logic [7:0] value);
    history[wr_pos] = value;
    wr_pos = wr_pos + 1'b1;
    if (wr_pos == '0) wrapped = 1'b1;
    expected_bytes.push_back('{value, 1'b0});
  endfunction

  // Decodes one compressed byte and queues the bytes it completes.
  function automatic void decode_beat(input logic [7:0] b, input logic last);
    int               before_cnt;
    int               run_len;
    int               span;
    int               i;
    logic [OFS_W-1:0] target;
    logic [7:0]       copied;
    decoded_t         tail;

    before_cnt = expected_bytes.size();
    case (phase)
      PH_CONTROL: begin
        held = b;
        if (b < CTRL_LIT) begin
          phase = PH_OFFSET;
        end else if (b < CTRL_PAD) begin
          remain = {1'b0, b[4:0]};
          phase  = PH_LITERAL;
        end else if (b < CTRL_REP) begin
          remain = {1'b0, b[4:0]} + RUN_EXTRA;
          phase  = PH_PAD;
        end else if (b < CTRL_ZERO) begin
          phase = PH_REPEAT;
        end else begin
          for (i = 0; i < int'(b[4:0]) + int'(RUN_EXTRA); i++) emit_byte(8'h00);
        end
      end
      PH_OFFSET: begin
        run_len = int'(held[6:2]) + int'(RUN_EXTRA);
        target  = {held[1:0], b} - OFS_BIAS;
        span    = (target < wr_pos) ? int'(wr_pos) - int'(target)
                                    : int'(wr_pos) + HISTORY_DEPTH_DEF - int'(target);
        // Each copied byte is read at the same distance behind the current
        // write slot, so short distances replicate freshly written bytes.
        for (i = 0; i < run_len; i++) begin
          if (!wrapped && int'(wr_pos) < span) copied = 8'h00;
          else copied = history[wr_pos - OFS_W'(span)];
          emit_byte(copied);
        end
        phase = PH_CONTROL;
      end
      PH_LITERAL: begin
        emit_byte(b);
        if (held != LIT_OPEN) begin
          remain = remain - 1'b1;
          if (remain == '0) phase = PH_CONTROL;
        end
      end
      PH_PAD: begin
        emit_byte(8'h00);
        emit_byte(b);
        remain = remain - 1'b1;
        if (remain == '0) phase = PH_CONTROL;
      end
      PH_REPEAT: begin
        for (i = 0; i < int'(held[4:0]) + int'(RUN_EXTRA); i++) emit_byte(b);
        phase = PH_CONTROL;
      end
      default: begin
        phase = PH_CONTROL;
      end
    endcase

    if (expected_bytes.size() > before_cnt) begin
      tail = expected_bytes.pop_back();
      tail.run_last = 1'b1;
      expected_bytes.push_back(tail);
    end
    if (last) clear_decoder();
  endfunction

  // Output beats are compared before the input beat of the same edge is
  // decoded, so a stray output can never match a fresh expectation.
  always @(posedge clk) begin
    decoded_t want;
    if (!rst_n) begin
      expected_bytes.delete();
      clear_decoder();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte: expected no beat, got %02h", out_byte);
          fails++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.value) begin
            $error("out_byte: expected %02h, got %02h", want.value, out_byte);
            fails++;
          end
          if (out_run_last !== want.run_last) begin
            $error("out_run_last: expected %0b, got %0b", want.run_last, out_run_last);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) decode_beat(in_byte, in_last);
    end
    fail_count    <= fails;
    pending_bytes <= expected_bytes.size();
  end

endmodule

FILE: tb/lz_rle_graphics_decompressor_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_rle_graphics_decompressor_unit_test
// Feeds compressed streams into the decompressor, first a directed set that
// covers every command and the stream-end cases, then random well-formed
// streams with some stray and cut-off bytes, under shifting back-pressure.
// ----------------------------------------------------------------------------
module lz_rle_graphics_decompressor_unit_test;
  import lzrgd_pkg::*;

  localparam int RESET_CYCLES   = 8;
  // Beat count after which the random streams stop being generated. The
  // directed part accounts for roughly two dozen of these beats.
  localparam int TOTAL_BEATS    = 522;
  // The idling mix changes every third of the run.
  localparam int PHASE_BEATS    = 174;
  // Cycles without any accepted beat on either channel before giving up.
  // A correct run never sees more than the latency plus a stall streak.
  localparam int WATCHDOG_LIMIT = 2000;
  // Quiet cycles after the last expected byte, to catch stray output beats.
  localparam int DRAIN_CYCLES   = 40;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;

  int fail_count;
  int pending_bytes;

  // Percent of cycles in which each side idles; changed by the stimulus.
  int send_idle = 0;
  int recv_idle = 0;
  int beats_sent = 0;
  int quiet_cycles = 0;

  // The stream under construction and the number of bytes it will decode to,
  // which lets the back-reference helper aim at a chosen distance.
  logic [7:0] stream_q[$];
  int         stream_len;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lz_rle_graphics_decompressor_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

  lzrgd_stream_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .fail_count    (fail_count),
    .pending_bytes (pending_bytes)
  );

  // The receiver stalls at random, independent of whether a beat is offered.
  always @(posedge clk) begin
    out_stall <= (recv_idle != 0) && ($urandom_range(99, 0) < recv_idle);
  end

  // Watchdog: any accepted beat on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one beat and returns at the edge where it is accepted. Valid is
  // left high on return, so back-to-back beats never lower and raise it in
  // the same time step.
  task automatic send_beat(input logic [7:0] value, input logic last);
    if (beats_sent < PHASE_BEATS) begin
      send_idle = 11;
      recv_idle = 54;
    end else if (beats_sent < 2 * PHASE_BEATS) begin
      send_idle = 54;
      recv_idle = 11;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    while (send_idle != 0 && $urandom_range(99, 0) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= value;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // Sends the built stream with the end marker on its final byte.
  task automatic send_stream();
    int i;
    for (i = 0; i < stream_q.size(); i++) send_beat(stream_q[i], i == stream_q.size() - 1);
  endtask

  // Back-reference of (len_code + 2) bytes at the given distance (1..1024)
  // behind the write position that the stream will have reached by then.
  task automatic add_backref(input int len_code, input int span);
    logic [OFS_W-1:0] field;
    field = OFS_W'(stream_len - span) + OFS_BIAS;
    stream_q.push_back({1'b0, 5'(len_code), field[9:8]});
    stream_q.push_back(field[7:0]);
    stream_len += len_code + 2;
  endtask

  task automatic add_literal_run(input int count);
    stream_q.push_back(CTRL_LIT | 8'(count));
    repeat (count) stream_q.push_back(8'($urandom));
    stream_len += count;
  endtask

  task automatic add_pad_run(input int code);
    stream_q.push_back(CTRL_PAD | 8'(code));
    repeat (code + 2) stream_q.push_back(8'($urandom));
    stream_len += 2 * (code + 2);
  endtask

  task automatic add_repeat(input int code, input logic [7:0] value);
    stream_q.push_back(CTRL_REP | 8'(code));
    stream_q.push_back(value);
    stream_len += code + 2;
  endtask

  task automatic add_zero_run(input int code);
    stream_q.push_back(CTRL_ZERO | 8'(code));
    stream_len += code + 2;
  endtask

  // A long stream uses the largest runs so that it decodes to well over one
  // window and its back-references read history after the ring has wrapped.
  // A short stream mixes all commands, its copies mostly of recent bytes, with the
  // occasional stray byte, open literal tail or cut-off ending.
  task automatic build_random_stream(input bit long_mode);
    int cmds;
    int k;
    int roll;
    stream_q.delete();
    stream_len = 0;
    cmds = long_mode ? 45 : $urandom_range(12, 1);
    for (k = 0; k < cmds; k++) begin
      roll = $urandom_range(99, 0);
      if (long_mode) begin
        if (roll < 40) add_backref(31, $urandom_range(1024, 1));
        else if (roll < 70) add_repeat($urandom_range(31, 24), 8'($urandom));
        else add_zero_run($urandom_range(31, 24));
      end else if (roll < 30) begin
        if (stream_len > 0 && $urandom_range(3, 0) != 0)
          add_backref($urandom_range(31, 0),
                      $urandom_range((stream_len < 40) ? stream_len : 40, 1));
        else
          add_backref($urandom_range(31, 0), $urandom_range(1024, 1));
      end else if (roll < 50) begin
        add_literal_run((roll < 32) ? $urandom_range(31, 1) : $urandom_range(6, 1));
      end else if (roll < 60) begin
        add_pad_run((roll < 52) ? $urandom_range(31, 0) : $urandom_range(3, 0));
      end else if (roll < 78) begin
        add_repeat($urandom_range(31, 0), 8'($urandom));
      end else if (roll < 93) begin
        add_zero_run($urandom_range(31, 0));
      end else begin
        // A stray byte shifts the meaning of everything after it.
        stream_q.push_back(8'($urandom));
      end
    end
    if ($urandom_range(9, 0) == 0) begin
      stream_q.push_back(LIT_OPEN);
      repeat ($urandom_range(6, 1)) stream_q.push_back(8'($urandom));
    end
    if ($urandom_range(6, 0) == 0) begin
      repeat ($urandom_range(2, 1)) begin
        if (stream_q.size() > 1) void'(stream_q.pop_back());
      end
    end
  endtask

  initial begin
    int stream_idx;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every command in one stream: a literal run with the byte extremes, a
    // distance-one overlapping copy, a maximum-length copy reaching back a
    // full window into bytes before stream start, the shortest pad run, the
    // longest repeat, and a maximum zero run whose control carries the end
    // marker and still emits.
    stream_q = '{CTRL_LIT | 8'd3, 8'h00, 8'hFF, 8'h5A};
    stream_len = 3;
    add_backref(0, 1);
    add_backref(31, 1024);
    stream_q.push_back(CTRL_PAD);
    stream_q.push_back(8'hFF);
    stream_q.push_back(8'h00);
    stream_len += 4;
    add_repeat(31, 8'hA5);
    add_zero_run(31);
    send_stream();

    // Open literal run, ended only by the stream end.
    stream_q = '{LIT_OPEN, 8'hAA, 8'h55};
    send_stream();
    // A repeat cut off after its control byte emits nothing.
    stream_q = '{CTRL_REP | 8'd5};
    send_stream();
    // So does a back-reference cut off before its offset byte.
    stream_q = '{8'h00};
    send_stream();
    // A pad run ended early still emits the pair for its last byte.
    stream_q = '{CTRL_PAD | 8'd3, 8'h12};
    send_stream();
    // Shortest zero run, alone in its stream.
    stream_q = '{CTRL_ZERO};
    send_stream();

    stream_idx = 0;
    while (beats_sent < TOTAL_BEATS) begin
      build_random_stream(stream_idx % 5 == 0);
      send_stream();
      stream_idx++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_bytes == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/lzrgd_pkg.sv
rtl/core/lzrgd_ram.sv
rtl/core/lzrgd_front.sv
rtl/core/lzrgd_queue.sv
rtl/core/lzrgd_back.sv
rtl/core/lz_rle_graphics_decompressor_unit.sv
tb/lzrgd_stream_checker.sv
tb/lz_rle_graphics_decompressor_unit_test.sv
